@@ src/command_to_can_frame_segmenter_core_defines.svh @@
// Assertion macros for the command-to-CAN-frame segmenter.
// Expects clk_i and rst_ni to be visible where the macros are used.
`ifndef COMMAND_TO_CAN_FRAME_SEGMENTER_CORE_DEFINES_SVH
`define COMMAND_TO_CAN_FRAME_SEGMENTER_CORE_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define CFS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define CFS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/cfs_pkg.sv @@
// Shared types and constants of the command-to-CAN-frame segmenter.
// No dependencies.
package cfs_pkg;

  localparam int unsigned PayloadMax = 7;
  localparam int unsigned ByteW      = 8;

  typedef enum logic [1:0] {
    PhAddress  = 2'd0,
    PhFunction = 2'd1,
    PhPayload  = 2'd2
  } phase_e;

  // Control broadcast to every payload cell.
  typedef struct packed {
    logic load;   // a payload byte is accepted this cycle
    logic clear;  // the current frame leaves or a command restarts
  } cell_ctrl_t;

endpackage

@@ src/cfs_if.sv @@
// Valid/ready channel interfaces for command bytes and CAN frames.
// Depends on nothing; used by the top level.
interface cfs_cmd_if;
  logic       valid;
  logic       ready;
  logic [7:0] cmd_byte;
  logic       end_of_command;

  modport source (output valid, cmd_byte, end_of_command, input ready);
  modport sink   (input valid, cmd_byte, end_of_command, output ready);
endinterface

interface cfs_frame_if;
  logic        valid;
  logic        ready;
  logic [15:0] frame_ext_id;
  logic [3:0]  frame_dlc;
  logic [7:0]  frame_byte0;
  logic [7:0]  frame_byte1;
  logic [7:0]  frame_byte2;
  logic [7:0]  frame_byte3;
  logic [7:0]  frame_byte4;
  logic [7:0]  frame_byte5;
  logic [7:0]  frame_byte6;
  logic [7:0]  frame_byte7;
  logic        final_frame;

  modport source (output valid, frame_ext_id, frame_dlc, frame_byte0, frame_byte1,
                  frame_byte2, frame_byte3, frame_byte4, frame_byte5, frame_byte6,
                  frame_byte7, final_frame, input ready);
  modport sink   (input valid, frame_ext_id, frame_dlc, frame_byte0, frame_byte1,
                  frame_byte2, frame_byte3, frame_byte4, frame_byte5, frame_byte6,
                  frame_byte7, final_frame, output ready);
endinterface

@@ src/command_to_can_frame_segmenter_core.sv @@
// Top level of the command-to-CAN-frame segmenter: header tracking, cell chain
// and frame output register. Depends on cfs_pkg, cfs_if and cfs_cell.
//
//   Channel  | Direction | Carries
//   ---------+-----------+---------------------------------------------------
//   cmd_i    | in        | one command byte and its end-of-command flag
//   frame_o  | out       | one extended-ID CAN data frame, ID, DLC, 8 bytes
//
// One command byte is taken every cycle unless the input stalls; a frame is
// shown in the cycle after the byte that completes it, via the output register.
// The input stalls only while a frame sits in the output register and the
// sink does not take it in that same cycle.
// Reset clears the header phase, fill count, packet number, the slot
// occupancy flags and the output valid; slot data has no reset.
`include "command_to_can_frame_segmenter_core_defines.svh"

module command_to_can_frame_segmenter_core import cfs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  cfs_cmd_if.sink     cmd_i,
  cfs_frame_if.source frame_o
);

  // Header and sequencing state.
  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] addr_q, addr_d;
  logic [ByteW-1:0] func_q, func_d;
  logic [2:0]       fill_q, fill_d;
  logic [ByteW-1:0] pkt_q, pkt_d;

  logic             accept;
  logic             last;
  logic             emit;
  cell_ctrl_t       cell_ctrl;

  // Cell chain: occupancy ripples from slot to slot, each slot shows its byte.
  logic [PayloadMax:0]          occ;
  logic [PayloadMax-1:0][7:0]   view;

  // Output register.
  logic        out_vq;
  logic [15:0] id_q;
  logic [3:0]  dlc_q;
  logic [7:0]  b0_q;
  logic [PayloadMax-1:0][7:0] pay_q;
  logic        fin_q;

  assign cmd_i.ready = !out_vq || frame_o.ready;
  assign accept      = cmd_i.valid && cmd_i.ready;
  assign last        = cmd_i.end_of_command;

  // A frame goes out on the seventh payload byte or on the command's last byte.
  assign emit = accept && (phase_q == PhPayload) &&
                ((fill_q == 3'(PayloadMax - 1)) || last);

  always_comb begin
    phase_d         = phase_q;
    addr_d          = addr_q;
    func_d          = func_q;
    fill_d          = fill_q;
    pkt_d           = pkt_q;
    cell_ctrl.load  = 1'b0;
    cell_ctrl.clear = 1'b0;
    if (accept) begin
      unique case (phase_q)
        PhAddress: begin
          addr_d = cmd_i.cmd_byte;
          if (!last) begin
            phase_d = PhFunction;
          end
          fill_d = '0;
          pkt_d  = '0;
        end
        PhFunction: begin
          func_d  = cmd_i.cmd_byte;
          phase_d = last ? PhAddress : PhPayload;
          fill_d  = '0;
          pkt_d   = '0;
        end
        PhPayload: begin
          cell_ctrl.load = 1'b1;
          fill_d         = fill_q + 3'd1;
          if (emit) begin
            cell_ctrl.clear = 1'b1;
            fill_d          = '0;
            if (last) begin
              phase_d = PhAddress;
              pkt_d   = '0;
            end else begin
              pkt_d = pkt_q + 8'd1;
            end
          end
        end
        default: begin
          phase_d         = PhAddress;
          fill_d          = '0;
          pkt_d           = '0;
          cell_ctrl.clear = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhAddress;
      addr_q  <= '0;
      func_q  <= '0;
      fill_q  <= '0;
      pkt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      addr_q  <= addr_d;
      func_q  <= func_d;
      fill_q  <= fill_d;
      pkt_q   <= pkt_d;
    end
  end

  // The first slot always sees a full left neighbor.
  assign occ[0] = 1'b1;

  for (genvar i = 0; i < PayloadMax; i++) begin : g_cell
    cfs_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (cell_ctrl),
      .byte_i     (cmd_i.cmd_byte),
      .prev_occ_i (occ[i]),
      .occ_o      (occ[i+1]),
      .view_o     (view[i])
    );
  end

  // The output register loads the assembled frame in the cycle of the
  // completing byte; unused slots already read as zero from the cells.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq <= 1'b0;
    end else if (emit) begin
      out_vq <= 1'b1;
    end else if (frame_o.ready) begin
      out_vq <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      id_q  <= {addr_q, pkt_q};
      dlc_q <= {1'b0, fill_q} + 4'd2;
      b0_q  <= func_q;
      pay_q <= view;
      fin_q <= last;
    end
  end

  assign frame_o.valid        = out_vq;
  assign frame_o.frame_ext_id = id_q;
  assign frame_o.frame_dlc    = dlc_q;
  assign frame_o.frame_byte0  = b0_q;
  assign frame_o.frame_byte1  = pay_q[0];
  assign frame_o.frame_byte2  = pay_q[1];
  assign frame_o.frame_byte3  = pay_q[2];
  assign frame_o.frame_byte4  = pay_q[3];
  assign frame_o.frame_byte5  = pay_q[4];
  assign frame_o.frame_byte6  = pay_q[5];
  assign frame_o.frame_byte7  = pay_q[6];
  assign frame_o.final_frame  = fin_q;

  // The occupancy ripple in the chain must agree with the fill count.
  `CFS_ASSERT_IMP(a_fill_matches_chain, 1'b1,
                  $countones(occ[PayloadMax:1]) == 32'(fill_q),
                  "cell occupancy disagrees with fill count")

  // After the final frame of a command the block waits for a fresh address.
  `CFS_ASSERT_NXT(a_final_restarts, emit && last,
                  phase_q == PhAddress && fill_q == 3'd0 && pkt_q == 8'd0,
                  "command did not restart after its final frame")

  // A frame on the output always carries between one and seven payload bytes.
  `CFS_ASSERT_IMP(a_dlc_range, frame_o.valid,
                  frame_o.frame_dlc >= 4'd2 && frame_o.frame_dlc <= 4'd8,
                  "frame DLC out of range")

endmodule

@@ src/cfs_cell.sv @@
// One payload slot of the segmenter's cell chain.
// Depends on cfs_pkg.
module cfs_cell import cfs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_ctrl_t       ctrl_i,
  input  logic [ByteW-1:0] byte_i,
  input  logic             prev_occ_i,
  output logic             occ_o,
  output logic [ByteW-1:0] view_o
);

  logic             occ_q, occ_d;
  logic [ByteW-1:0] data_q;
  logic             wr;

  // The slot takes the byte when its left neighbor is full and it is still empty.
  assign wr = ctrl_i.load & prev_occ_i & ~occ_q;

  always_comb begin
    occ_d = occ_q;
    if (ctrl_i.clear) begin
      occ_d = 1'b0;
    end else if (wr) begin
      occ_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      data_q <= byte_i;
    end
  end

  assign occ_o  = occ_q;
  assign view_o = occ_q ? data_q : (wr ? byte_i : '0);

endmodule

@@ tb/sv/command_to_can_frame_segmenter_core_tb.sv @@
// Self-checking testbench for the command-to-CAN-frame segmenter core.
// Depends on cfs_pkg, cfs_if and the segmenter RTL; drives command bytes and
// checks every CAN frame against an in-bench segmentation model.
module command_to_can_frame_segmenter_core_tb;
  import cfs_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  // One CAN frame as seen on the output channel; data[0] is the function code.
  typedef struct packed {
    logic [15:0]     ext_id;
    logic [3:0]      dlc;
    logic [7:0][7:0] data;
    logic            final_frame;
  } can_frame_t;

  // Segmentation model plus the queue of frames it still expects to see.
  class can_frame_scoreboard;
    phase_e       phase;
    logic [7:0]   address;
    logic [7:0]   func_code;
    logic [7:0]   held[PayloadMax];
    int unsigned  fill;
    logic [7:0]   packet_no;
    can_frame_t   pending_frames[$];
    int unsigned  errors;
    int unsigned  frames_checked;
    int unsigned  packet_wraps;

    function new();
      errors         = 0;
      frames_checked = 0;
      packet_wraps   = 0;
      address        = '0;
      func_code      = '0;
      restart();
    endfunction

    function void restart();
      phase     = PhAddress;
      fill      = 0;
      packet_no = '0;
    endfunction

    function int unsigned pending();
      return pending_frames.size();
    endfunction

    // Called for every accepted command byte; queues a frame when one is due.
    function void segment_byte(logic [7:0] b, logic last);
      can_frame_t f;
      case (phase)
        PhAddress: begin
          address = b;
          if (last) restart();
          else phase = PhFunction;
        end
        PhFunction: begin
          func_code = b;
          if (last) begin
            restart();
          end else begin
            phase = PhPayload;
            fill  = 0;
          end
        end
        default: begin
          if (fill >= PayloadMax) fill = 0;
          held[fill] = b;
          fill++;
          if (fill == PayloadMax || last) begin
            f             = '0;
            f.ext_id      = {address, packet_no};
            f.dlc         = 4'(fill + 1);
            f.data[0]     = func_code;
            for (int i = 0; i < PayloadMax; i++) begin
              if (i < fill) f.data[i + 1] = held[i];
            end
            f.final_frame = last;
            pending_frames.push_back(f);
            if (last) begin
              restart();
            end else begin
              fill = 0;
              if (packet_no == 8'hFF) packet_wraps++;
              packet_no++;
            end
          end
        end
      endcase
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    // Compares one received frame with the oldest expected one.
    task check_frame(can_frame_t got);
      can_frame_t exp;
      if (pending_frames.size() == 0) begin
        report($sformatf("unexpected frame id %h dlc %0d", got.ext_id, got.dlc));
        return;
      end
      exp = pending_frames.pop_front();
      frames_checked++;
      if (got.ext_id !== exp.ext_id)
        report($sformatf("frame_ext_id got %h expected %h", got.ext_id, exp.ext_id));
      if (got.dlc !== exp.dlc)
        report($sformatf("frame_dlc got %0d expected %0d (id %h)", got.dlc, exp.dlc,
                         exp.ext_id));
      for (int i = 0; i < 8; i++) begin
        if (got.data[i] !== exp.data[i])
          report($sformatf("frame_byte%0d got %h expected %h (id %h)", i, got.data[i],
                           exp.data[i], exp.ext_id));
      end
      if (got.final_frame !== exp.final_frame)
        report($sformatf("final_frame got %b expected %b (id %h)", got.final_frame,
                         exp.final_frame, exp.ext_id));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  cfs_cmd_if   cmd ();
  cfs_frame_if frame ();

  command_to_can_frame_segmenter_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .frame_o (frame)
  );

  can_frame_scoreboard frames = new();

  // Set for the closing stretch of the run: no gaps on either side.
  bit          quiet;
  int unsigned bytes_sent;
  int unsigned commands_sent;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Presents one byte and holds it until the block takes it. A random gap of
  // idle cycles may come first.
  task send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 14);
      cmd.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd.valid          <= 1'b1;
    cmd.cmd_byte       <= b;
    cmd.end_of_command <= last;
    do @(posedge clk_i); while (!(cmd.valid && cmd.ready));
    frames.segment_byte(b, last);
    bytes_sent++;
  endtask

  task send_command(input byte_q_t seq);
    for (int i = 0; i < seq.size(); i++) send_byte(seq[i], i == seq.size() - 1);
    commands_sent++;
  endtask

  // A command of n bytes in total with random address, function and payload.
  task send_random_command(input int unsigned n);
    byte_q_t seq;
    for (int i = 0; i < n; i++) seq.push_back(8'($urandom_range(0, 255)));
    send_command(seq);
  endtask

  // Sender holds off until every frame owed so far has been received.
  task drain_frames();
    cmd.valid <= 1'b0;
    do @(posedge clk_i); while (frames.pending() != 0);
  endtask

  // Frame sink: checks every transaction and stalls in random bursts.
  initial begin
    int unsigned stall_left;
    logic        rdy_nxt;
    can_frame_t  got;
    stall_left = 0;
    frame.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (frame.valid && frame.ready) begin
        got.ext_id      = frame.frame_ext_id;
        got.dlc         = frame.frame_dlc;
        got.data[0]     = frame.frame_byte0;
        got.data[1]     = frame.frame_byte1;
        got.data[2]     = frame.frame_byte2;
        got.data[3]     = frame.frame_byte3;
        got.data[4]     = frame.frame_byte4;
        got.data[5]     = frame.frame_byte5;
        got.data[6]     = frame.frame_byte6;
        got.data[7]     = frame.frame_byte7;
        got.final_frame = frame.final_frame;
        frames.check_frame(got);
      end
      if (quiet) begin
        stall_left = 0;
        rdy_nxt    = 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        rdy_nxt = (stall_left == 0);
      end else if ($urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 14);
        rdy_nxt    = 1'b0;
      end else begin
        rdy_nxt = 1'b1;
      end
      frame.ready <= rdy_nxt;
    end
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #6_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int unsigned kind;
    int unsigned payload;
    int unsigned long_len;
    quiet         = 1'b0;
    bytes_sent    = 0;
    commands_sent = 0;
    rst_ni             <= 1'b0;
    cmd.valid          <= 1'b0;
    cmd.cmd_byte       <= '0;
    cmd.end_of_command <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Commands ending on the address or on the function byte
    // must produce no frame and restart the header.
    send_command({8'h5A});
    send_command({8'hA5, 8'h3C});
    // Single payload byte, extreme header values.
    send_command({8'hFF, 8'h00, 8'hFF});
    // Payload of exactly seven: one full frame that is also the last one.
    send_command({8'h00, 8'hFF, 8'h00, 8'hFF, 8'hAA, 8'h55, 8'h01, 8'h80, 8'h7F});
    // Eight payload bytes: a full frame, then a final frame with one byte.
    send_command({8'h81, 8'h7E, 8'h55, 8'hAA, 8'hFF, 8'h00, 8'h12, 8'h34, 8'h56,
                  8'h78});
    drain_frames();

    // One long command with many full frames and a short final one.
    long_len = 40 * PayloadMax + 5;
    send_random_command(long_len + 2);
    drain_frames();

    // Random commands: mostly ordinary lengths, some multiples of seven and
    // a few header-only commands. The closing stretch runs without gaps.
    while (bytes_sent < 850) begin
      if (bytes_sent > 720) quiet = 1'b1;
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        send_random_command($urandom_range(1, 2));
      end else begin
        if (kind < 22) payload = PayloadMax * $urandom_range(1, 4);
        else payload = $urandom_range(1, 30);
        send_random_command(payload + 2);
      end
      if (!quiet && $urandom_range(0, 14) == 0) drain_frames();
    end
    cmd.valid <= 1'b0;

    do @(posedge clk_i); while (frames.pending() != 0);
    repeat (10) @(posedge clk_i);

    $display("Sent %0d commands (%0d bytes); %0d frames checked, %0d packet wraps.",
             commands_sent, bytes_sent, frames.frames_checked, frames.packet_wraps);
    $display("Covered header-only commands, full and partial frames and random stalls.");
    if (frames.errors == 0 && frames.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
